// ===== rtl/cbct_pkg.sv =====
// Package for the color blob centroid tracker.
// Widths, limits, register indexes, reset values, the sequencer state type and the divider operation type.
// No dependencies.
package cbct_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 128;

    localparam int X_W   = $clog2(MAX_WIDTH);
    localparam int Y_W   = $clog2(MAX_HEIGHT);
    localparam int CNT_W = 16;
    localparam int SX_W  = 23;
    localparam int SY_W  = 22;
    localparam int FN_W  = 32;

    localparam int CNT_MAX = MAX_WIDTH * MAX_HEIGHT;

    // shared divider
    localparam int NUM_W = 26;
    localparam int DEN_W = 24;
    localparam int QUO_W = 10;
    localparam int DCNT_W = $clog2(NUM_W);

    localparam int MAX_GRID = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_RED_MIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd7;

    localparam logic [7:0] RED_MIN_RST      = 8'd100;
    localparam logic [7:0] GREEN_MIN_RST    = 8'd90;
    localparam logic [7:0] BLUE_MAX_RST     = 8'd20;
    localparam logic [8:0] FRAME_WIDTH_RST  = 9'd144;
    localparam logic [8:0] CELL_WIDTH_RST   = 9'd24;
    localparam logic [7:0] CELL_HEIGHT_RST  = 8'd15;
    localparam logic [4:0] GRID_COLUMNS_RST = 5'd6;
    localparam logic [4:0] GRID_ROWS_RST    = 5'd5;

    localparam logic [8:0]  LAST_CELL_RST   = 9'h1FE;
    localparam logic [9:0]  LAST_X2_RST     = 10'h3FF;
    localparam logic [8:0]  LAST_Y2_RST     = 9'h1FF;
    localparam logic [13:0] LAST_BUCKET_RST = 14'h3FFF;

    // output beat layout
    localparam int OUT_DATA_W = 80;
    localparam int IN_DATA_W  = 24;

    typedef enum logic [4:0] {
        ST_PIX   = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_CELL  = 5'b01000,
        ST_CMP   = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        OP_COL = 2'd0,
        OP_ROW = 2'd1,
        OP_CX2 = 2'd2,
        OP_CY2 = 2'd3
    } div_op_t;

endpackage

// ===== rtl/color_blob_centroid_tracker_core.sv =====
// Color blob centroid tracker: pixel accumulation, shared iterative divider
// and change-detecting result output. Depends on cbct_pkg.
//
// Usage:
//   Slave stream: one RGB pixel per beat in raster order, tlast on the last
//   pixel of a frame. Pixels that are not the last of a frame are taken one
//   per clock. The beat with tlast starts the end-of-frame sequence, during
//   which s_tready is low: for a frame with blob pixels, four divisions on
//   the one shared restoring divider, then the cell and compare steps; for a
//   frame without any, the compare step alone.
//   Master stream: one result beat per frame, only when grid cell, doubled
//   centroid or count bucket changed from the last result; it appears in the
//   cycle after the sequence ends and is held in an output register until
//   taken. Pixels of the next frame are accepted meanwhile; a stalled
//   receiver holds the block only when the next frame's result is ready.
//   Configuration: cfg_we/cfg_index/cfg_data, one register per write, taken
//   at once; write only while the block is idle.
//   Reset: registers to defaults, counters and sums cleared, no beat pending.
module color_blob_centroid_tracker_core
    import cbct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] red_level, [15:8] green_level, [23:16] blue_level
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] frame_number, [40:32] grid_cell, [50:41] center_x2,
    // [59:51] center_y2, [75:60] pixel_count, [79:76] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // [0] blob_found
    output logic                  m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [7:0] red_min_reg, red_min_next;
    logic [7:0] green_min_reg, green_min_next;
    logic [7:0] blue_max_reg, blue_max_next;
    logic [8:0] frame_width_reg, frame_width_next;
    logic [8:0] cell_width_reg, cell_width_next;
    logic [7:0] cell_height_reg, cell_height_next;
    logic [4:0] grid_columns_reg, grid_columns_next;
    logic [4:0] grid_rows_reg, grid_rows_next;

    logic [X_W-1:0]   x_reg, x_next;
    logic [Y_W-1:0]   y_reg, y_next;
    logic [SX_W-1:0]  sum_x_reg, sum_x_next;
    logic [SY_W-1:0]  sum_y_reg, sum_y_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [FN_W-1:0]  frame_counter_reg, frame_counter_next;
    logic [8:0]       last_cell_reg, last_cell_next;
    logic [9:0]       last_x2_reg, last_x2_next;
    logic [8:0]       last_y2_reg, last_y2_next;
    logic [13:0]      last_bucket_reg, last_bucket_next;
    logic             out_valid_reg, out_valid_next;
    div_op_t          op_reg, op_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [QUO_W-1:0] col_q_reg, col_q_next;
    logic [QUO_W-1:0] row_q_reg, row_q_next;
    logic [9:0]       cx2_reg, cx2_next;
    logic [8:0]       cy2_reg, cy2_next;
    logic [8:0]       cell_reg, cell_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic             out_user_reg, out_user_next;

    logic [7:0]       red_level, green_level, blue_level;
    logic             accept, hit;
    logic [8:0]       fw_eff, cw_eff, x_inc;
    logic [7:0]       ch_eff;
    logic [4:0]       cols_eff, rows_eff, cols_m1, rows_m1;
    logic [3:0]       col_sel, row_sel;
    logic [24:0]      mul_prod;
    logic [8:0]       mul_b;
    logic [DEN_W:0]   trial, diff;
    logic             ge;
    logic [QUO_W-1:0] quo_new;
    logic             changed, out_busy;

    assign red_level   = s_tdata[7:0];
    assign green_level = s_tdata[15:8];
    assign blue_level  = s_tdata[23:16];

    assign s_tready = (state_reg == ST_PIX);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign hit = (red_level >= red_min_reg) && (green_level >= green_min_reg)
              && (blue_level <= blue_max_reg)
              && ({1'b0, count_reg} < (CNT_W+1)'(CNT_MAX));

    always_comb
    begin
        if (frame_width_reg == 9'd0)
            fw_eff = 9'd1;
        else if ({1'b0, frame_width_reg} > 10'(MAX_WIDTH))
            fw_eff = 9'(MAX_WIDTH);
        else
            fw_eff = frame_width_reg;
        cw_eff   = (cell_width_reg == 9'd0) ? 9'd1 : cell_width_reg;
        ch_eff   = (cell_height_reg == 8'd0) ? 8'd1 : cell_height_reg;
        if (grid_columns_reg == 5'd0)
            cols_eff = 5'd1;
        else if (grid_columns_reg > 5'(MAX_GRID))
            cols_eff = 5'(MAX_GRID);
        else
            cols_eff = grid_columns_reg;
        if (grid_rows_reg == 5'd0)
            rows_eff = 5'd1;
        else if (grid_rows_reg > 5'(MAX_GRID))
            rows_eff = 5'(MAX_GRID);
        else
            rows_eff = grid_rows_reg;
    end

    assign cols_m1 = cols_eff - 5'd1;
    assign rows_m1 = rows_eff - 5'd1;
    assign col_sel = (col_q_reg > {5'd0, cols_m1}) ? cols_m1[3:0] : col_q_reg[3:0];
    assign row_sel = (row_q_reg > {5'd0, rows_m1}) ? rows_m1[3:0] : row_q_reg[3:0];

    assign x_inc = {1'b0, x_reg} + 9'd1;

    assign mul_b    = (op_reg == OP_COL) ? cw_eff : {1'b0, ch_eff};
    assign mul_prod = count_reg * mul_b;

    assign trial   = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = trial - {1'b0, den_reg};
    assign ge      = (trial >= {1'b0, den_reg});
    assign quo_new = {quo_reg[QUO_W-2:0], ge};

    assign changed = (cell_reg != last_cell_reg) || (cx2_reg != last_x2_reg)
                  || (cy2_reg != last_y2_reg) || (count_reg[15:2] != last_bucket_reg);
    assign out_busy = out_valid_reg && !m_tready;

    always_comb
    begin
        state_next         = state_reg;
        red_min_next       = red_min_reg;
        green_min_next     = green_min_reg;
        blue_max_next      = blue_max_reg;
        frame_width_next   = frame_width_reg;
        cell_width_next    = cell_width_reg;
        cell_height_next   = cell_height_reg;
        grid_columns_next  = grid_columns_reg;
        grid_rows_next     = grid_rows_reg;
        x_next             = x_reg;
        y_next             = y_reg;
        sum_x_next         = sum_x_reg;
        sum_y_next         = sum_y_reg;
        count_next         = count_reg;
        frame_counter_next = frame_counter_reg;
        last_cell_next     = last_cell_reg;
        last_x2_next       = last_x2_reg;
        last_y2_next       = last_y2_reg;
        last_bucket_next   = last_bucket_reg;
        out_valid_next     = m_tready ? 1'b0 : out_valid_reg;
        op_next            = op_reg;
        dcnt_next          = dcnt_reg;
        num_next           = num_reg;
        den_next           = den_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        col_q_next         = col_q_reg;
        row_q_next         = row_q_reg;
        cx2_next           = cx2_reg;
        cy2_next           = cy2_reg;
        cell_next          = cell_reg;
        out_data_next      = out_data_reg;
        out_user_next      = out_user_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RED_MIN:      red_min_next      = cfg_data[7:0];
                REG_GREEN_MIN:    green_min_next    = cfg_data[7:0];
                REG_BLUE_MAX:     blue_max_next     = cfg_data[7:0];
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data[8:0];
                REG_CELL_WIDTH:   cell_width_next   = cfg_data[8:0];
                REG_CELL_HEIGHT:  cell_height_next  = cfg_data[7:0];
                REG_GRID_COLUMNS: grid_columns_next = cfg_data[4:0];
                REG_GRID_ROWS:    grid_rows_next    = cfg_data[4:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_PIX:
            begin
                if (accept)
                begin
                    if (hit)
                    begin
                        sum_x_next = sum_x_reg + SX_W'(x_reg);
                        sum_y_next = sum_y_reg + SY_W'(y_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast)
                    begin
                        x_next  = '0;
                        y_next  = '0;
                        op_next = OP_COL;
                        if (!hit && count_reg == '0)
                        begin
                            cell_next  = 9'h1FF;
                            cx2_next   = 10'h3FF;
                            cy2_next   = 9'h1FF;
                            state_next = ST_CMP;
                        end
                        else
                        begin
                            state_next = ST_SETUP;
                        end
                    end
                    else if (x_inc >= fw_eff)
                    begin
                        x_next = '0;
                        y_next = (y_reg == Y_W'(MAX_HEIGHT - 1)) ? '0 : y_reg + Y_W'(1);
                    end
                    else
                    begin
                        x_next = x_inc[X_W-1:0];
                    end
                end
            end
            ST_SETUP:
            begin
                rem_next  = '0;
                quo_next  = '0;
                dcnt_next = '0;
                unique case (op_reg)
                    OP_COL:
                    begin
                        num_next = NUM_W'(sum_x_reg);
                        den_next = mul_prod[DEN_W-1:0];
                    end
                    OP_ROW:
                    begin
                        num_next = NUM_W'(sum_y_reg);
                        den_next = mul_prod[DEN_W-1:0];
                    end
                    OP_CX2:
                    begin
                        num_next = {1'b0, sum_x_reg, 2'b00} + NUM_W'(count_reg);
                        den_next = DEN_W'({count_reg, 1'b0});
                    end
                    OP_CY2:
                    begin
                        num_next = {2'b00, sum_y_reg, 2'b00} + NUM_W'(count_reg);
                        den_next = DEN_W'({count_reg, 1'b0});
                    end
                    default: ;
                endcase
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_next  = {num_reg[NUM_W-2:0], 1'b0};
                quo_next  = quo_new;
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(NUM_W - 1))
                begin
                    unique case (op_reg)
                        OP_COL:  col_q_next = quo_new;
                        OP_ROW:  row_q_next = quo_new;
                        OP_CX2:  cx2_next   = quo_new;
                        OP_CY2:  cy2_next   = quo_new[8:0];
                        default: ;
                    endcase
                    if (op_reg == OP_CY2)
                    begin
                        state_next = ST_CELL;
                    end
                    else
                    begin
                        op_next    = div_op_t'(op_reg + 2'd1);
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_CELL:
            begin
                cell_next  = {5'd0, row_sel} * {4'd0, cols_eff} + {5'd0, col_sel};
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!(changed && out_busy))
                begin
                    if (changed)
                    begin
                        out_valid_next   = 1'b1;
                        out_data_next    = {4'd0, count_reg, cy2_reg, cx2_reg, cell_reg,
                                            frame_counter_reg};
                        out_user_next    = (count_reg != '0);
                        last_cell_next   = cell_reg;
                        last_x2_next     = cx2_reg;
                        last_y2_next     = cy2_reg;
                        last_bucket_next = count_reg[15:2];
                    end
                    sum_x_next         = '0;
                    sum_y_next         = '0;
                    count_next         = '0;
                    frame_counter_next = frame_counter_reg + FN_W'(1);
                    state_next         = ST_PIX;
                end
            end
            default: state_next = ST_PIX;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_PIX;
            red_min_reg       <= RED_MIN_RST;
            green_min_reg     <= GREEN_MIN_RST;
            blue_max_reg      <= BLUE_MAX_RST;
            frame_width_reg   <= FRAME_WIDTH_RST;
            cell_width_reg    <= CELL_WIDTH_RST;
            cell_height_reg   <= CELL_HEIGHT_RST;
            grid_columns_reg  <= GRID_COLUMNS_RST;
            grid_rows_reg     <= GRID_ROWS_RST;
            x_reg             <= '0;
            y_reg             <= '0;
            sum_x_reg         <= '0;
            sum_y_reg         <= '0;
            count_reg         <= '0;
            frame_counter_reg <= '0;
            last_cell_reg     <= LAST_CELL_RST;
            last_x2_reg       <= LAST_X2_RST;
            last_y2_reg       <= LAST_Y2_RST;
            last_bucket_reg   <= LAST_BUCKET_RST;
            out_valid_reg     <= 1'b0;
            op_reg            <= OP_COL;
            dcnt_reg          <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            red_min_reg       <= red_min_next;
            green_min_reg     <= green_min_next;
            blue_max_reg      <= blue_max_next;
            frame_width_reg   <= frame_width_next;
            cell_width_reg    <= cell_width_next;
            cell_height_reg   <= cell_height_next;
            grid_columns_reg  <= grid_columns_next;
            grid_rows_reg     <= grid_rows_next;
            x_reg             <= x_next;
            y_reg             <= y_next;
            sum_x_reg         <= sum_x_next;
            sum_y_reg         <= sum_y_next;
            count_reg         <= count_next;
            frame_counter_reg <= frame_counter_next;
            last_cell_reg     <= last_cell_next;
            last_x2_reg       <= last_x2_next;
            last_y2_reg       <= last_y2_next;
            last_bucket_reg   <= last_bucket_next;
            out_valid_reg     <= out_valid_next;
            op_reg            <= op_next;
            dcnt_reg          <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        col_q_reg    <= col_q_next;
        row_q_reg    <= row_q_next;
        cx2_reg      <= cx2_next;
        cy2_reg      <= cy2_next;
        cell_reg     <= cell_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

`ifndef SYNTH
    a_new_beat_from_compare: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_CMP))
        else $error("result beat raised outside compare step");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} <= (CNT_W+1)'(CNT_MAX)))
        else $error("blob count beyond limit");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> !s_tready)
        else $error("pixel taken right after frame end");
`endif

endmodule
